[hw/rtl/scale_ema_tare_weigh_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the load-cell weighing block
// Clock and reset are taken from the scope of the module that uses them.
// ----------------------------------------------------------------------------
`ifndef SCALE_EMA_TARE_WEIGH_ASSERT_SVH
`define SCALE_EMA_TARE_WEIGH_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define SEW_ASSERT_IMP(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("scale_ema_tare_weigh: same-cycle check failed");

// Next-cycle implication, checked outside reset
`define SEW_ASSERT_NXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("scale_ema_tare_weigh: next-cycle check failed");

`endif

[hw/rtl/sew_pkg.sv]
// ----------------------------------------------------------------------------
// sew_pkg
// Types, widths and constants shared by the weighing block controller,
// datapath and top level.
// ----------------------------------------------------------------------------
package sew_pkg;

   // Field and register widths
   localparam int SampleWidth = 12;
   localparam int WeightWidth = 21;
   localparam int AlphaWidth  = 17;
   localparam int LevelWidth  = 13;
   localparam int GainWidth   = 24;
   localparam int AvgWidth    = 28;
   localparam int CsrIdxWidth = 2;
   localparam int CsrDataWidth = 24;

   // Multiplier operand and product widths
   localparam int MulXWidth = 24;
   localparam int MulYWidth = 17;
   localparam int ProdWidth = MulXWidth + MulYWidth;
   localparam int AccWidth  = 34;

   // Fixed-point constants
   localparam logic [AlphaWidth-1:0]  OneQ16   = 17'd65536;
   localparam logic [SampleWidth-1:0] LevelMax = 12'd4095;

   // Register reset values
   localparam logic [AlphaWidth-1:0] AlphaReset     = 17'd655;
   localparam logic [LevelWidth-1:0] ThresholdReset = 13'd1;
   localparam logic [LevelWidth-1:0] ClampReset     = 13'd5000;
   localparam logic [GainWidth-1:0]  GainReset      = 24'd6554911;

   // Register indexes
   localparam logic [CsrIdxWidth-1:0] CsrAlpha     = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CsrThreshold = 2'd1;
   localparam logic [CsrIdxWidth-1:0] CsrClamp     = 2'd2;
   localparam logic [CsrIdxWidth-1:0] CsrGain      = 2'd3;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_LO,
      ST_MUL_SAMPLE,
      ST_MUL_HI,
      ST_FILTER,
      ST_LEVEL,
      ST_MUL_WEIGHT,
      ST_OUTPUT
   } state_type;

   // Multiplier operand selection
   typedef enum logic [1:0] {
      MUL_AVG_LO,
      MUL_SAMPLE,
      MUL_AVG_HI,
      MUL_WEIGHT
   } mul_sel_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic        load;
      logic        seed;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        acc_init;
      logic        acc_add;
      logic        avg_commit;
      logic        level_en;
      logic        out_load;
   } dp_cmd_type;

endpackage

[hw/rtl/sew_ctrl.sv]
// ----------------------------------------------------------------------------
// sew_ctrl
// Sequencer for the weighing block: seeds on the first request, then steps
// the datapath through the average update, tare and scaling, and owns the
// result valid flag.
// ----------------------------------------------------------------------------
module sew_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output sew_pkg::dp_cmd_type cmd
);

   sew_pkg::state_type state_ff, state_in;
   logic               seeded_ff, seeded_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               out_free;

   // Take requests only when idle
   assign req_stall = (state_ff != sew_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Next state
   always_comb begin
      state_in  = state_ff;
      seeded_in = seeded_ff;
      case (state_ff)
         sew_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (seeded_ff) begin
                  state_in = sew_pkg::ST_MUL_LO;
               end else begin
                  seeded_in = 1'b1;
               end
            end
         end
         sew_pkg::ST_MUL_LO:     state_in = sew_pkg::ST_MUL_SAMPLE;
         sew_pkg::ST_MUL_SAMPLE: state_in = sew_pkg::ST_MUL_HI;
         sew_pkg::ST_MUL_HI:     state_in = sew_pkg::ST_FILTER;
         sew_pkg::ST_FILTER:     state_in = sew_pkg::ST_LEVEL;
         sew_pkg::ST_LEVEL:      state_in = sew_pkg::ST_MUL_WEIGHT;
         sew_pkg::ST_MUL_WEIGHT: state_in = sew_pkg::ST_OUTPUT;
         sew_pkg::ST_OUTPUT: begin
            if (out_free) begin
               state_in = sew_pkg::ST_IDLE;
            end
         end
         default: state_in = sew_pkg::ST_IDLE;
      endcase
   end

   // Datapath commands
   always_comb begin
      cmd         = '0;
      cmd.mul_sel = sew_pkg::MUL_AVG_LO;
      case (state_ff)
         sew_pkg::ST_IDLE: begin
            cmd.load = req_valid && seeded_ff;
            cmd.seed = req_valid && !seeded_ff;
         end
         sew_pkg::ST_MUL_LO: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = sew_pkg::MUL_AVG_LO;
         end
         sew_pkg::ST_MUL_SAMPLE: begin
            cmd.mul_en   = 1'b1;
            cmd.mul_sel  = sew_pkg::MUL_SAMPLE;
            cmd.acc_init = 1'b1;
         end
         sew_pkg::ST_MUL_HI: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = sew_pkg::MUL_AVG_HI;
            cmd.acc_add = 1'b1;
         end
         sew_pkg::ST_FILTER:     cmd.avg_commit = 1'b1;
         sew_pkg::ST_LEVEL:      cmd.level_en   = 1'b1;
         sew_pkg::ST_MUL_WEIGHT: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = sew_pkg::MUL_WEIGHT;
         end
         sew_pkg::ST_OUTPUT:     cmd.out_load = out_free;
         default: begin
            cmd.mul_en = 1'b0;
         end
      endcase
   end

   // Hold the result until taken, set it on a fresh load
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sew_pkg::ST_IDLE;
         seeded_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seeded_ff    <= seeded_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[hw/rtl/sew_dp.sv]
// ----------------------------------------------------------------------------
// sew_dp
// Datapath of the weighing block: control registers, moving average with
// one shared multiplier, tare level, threshold and clamp, output register.
// ----------------------------------------------------------------------------
module sew_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_en,
   input  logic [sew_pkg::CsrIdxWidth-1:0]     csr_index,
   input  logic [sew_pkg::CsrDataWidth-1:0]    csr_wdata,
   input  logic [sew_pkg::SampleWidth-1:0]     req_sample,
   input  logic                                req_tare_pressed,
   input  sew_pkg::dp_cmd_type                 cmd,
   output logic [sew_pkg::WeightWidth-1:0]     rsp_weight_centigrams,
   output logic [sew_pkg::SampleWidth-1:0]     rsp_filtered_level
);

   // Control registers
   logic [sew_pkg::AlphaWidth-1:0] alpha_ff;
   logic [sew_pkg::LevelWidth-1:0] threshold_ff;
   logic [sew_pkg::LevelWidth-1:0] clamp_ff;
   logic [sew_pkg::GainWidth-1:0]  gain_ff;

   // Filter state
   logic [sew_pkg::AvgWidth-1:0]    avg_ff, avg_in;
   logic [sew_pkg::SampleWidth-1:0] tare_ff;

   // Working registers
   logic [sew_pkg::SampleWidth-1:0] sample_ff;
   logic                            tare_req_ff;
   logic [sew_pkg::ProdWidth-1:0]   prod_ff, prod_in;
   logic signed [sew_pkg::AccWidth-1:0] acc_ff, acc_in;
   logic [sew_pkg::SampleWidth-1:0] filtered_ff;
   logic [sew_pkg::LevelWidth-1:0]  level_ff, level_in;
   logic [sew_pkg::WeightWidth-1:0] weight_out_ff;
   logic [sew_pkg::SampleWidth-1:0] filtered_out_ff;

   logic [sew_pkg::AlphaWidth-1:0] alpha_sat;
   logic [sew_pkg::MulXWidth-1:0]  mul_x;
   logic [sew_pkg::MulYWidth-1:0]  mul_y;
   logic signed [34:0]             rnd_diff;
   logic signed [34:0]             rnd_corr;
   logic signed [sew_pkg::AccWidth-1:0] prod_s;
   logic [28:0]                    rnd_sum;
   logic [12:0]                    filt_raw;
   logic [sew_pkg::SampleWidth-1:0] filtered_in;
   logic [sew_pkg::SampleWidth-1:0] tare_eff;
   logic signed [13:0]             diff;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff     <= sew_pkg::AlphaReset;
         threshold_ff <= sew_pkg::ThresholdReset;
         clamp_ff     <= sew_pkg::ClampReset;
         gain_ff      <= sew_pkg::GainReset;
      end else if (csr_write_en) begin
         case (csr_index)
            sew_pkg::CsrAlpha:     alpha_ff     <= csr_wdata[sew_pkg::AlphaWidth-1:0];
            sew_pkg::CsrThreshold: threshold_ff <= csr_wdata[sew_pkg::LevelWidth-1:0];
            sew_pkg::CsrClamp:     clamp_ff     <= csr_wdata[sew_pkg::LevelWidth-1:0];
            sew_pkg::CsrGain:      gain_ff      <= csr_wdata[sew_pkg::GainWidth-1:0];
            default: begin
               gain_ff <= gain_ff;
            end
         endcase
      end
   end

   // Saturate alpha at one
   assign alpha_sat = (alpha_ff > sew_pkg::OneQ16) ? sew_pkg::OneQ16 : alpha_ff;

   // Shared multiplier operands
   always_comb begin
      mul_y = alpha_sat;
      case (cmd.mul_sel)
         sew_pkg::MUL_AVG_LO: mul_x = {8'd0, avg_ff[15:0]};
         sew_pkg::MUL_SAMPLE: mul_x = {12'd0, sample_ff};
         sew_pkg::MUL_AVG_HI: mul_x = {12'd0, avg_ff[27:16]};
         sew_pkg::MUL_WEIGHT: begin
            mul_x = gain_ff;
            mul_y = {4'd0, level_ff};
         end
         default: mul_x = '0;
      endcase
   end

   assign prod_in = mul_x * mul_y;

   // Average update, split so that
   // new = avg + a*s - a*hi + floor((0x8000 - a*lo) / 2^16)
   assign rnd_diff = 35'sd32768 - $signed({2'b00, prod_ff[32:0]});
   assign rnd_corr = rnd_diff >>> 16;
   assign prod_s   = $signed({1'b0, prod_ff[32:0]});

   always_comb begin
      acc_in = acc_ff;
      if (cmd.acc_init) begin
         acc_in = $signed({6'd0, avg_ff}) + rnd_corr[sew_pkg::AccWidth-1:0];
      end else if (cmd.acc_add) begin
         acc_in = acc_ff + prod_s;
      end
   end

   always_comb begin
      avg_in = avg_ff;
      if (cmd.seed) begin
         avg_in = {req_sample, 16'd0};
      end else if (cmd.avg_commit) begin
         avg_in = avg_ff;
         avg_in = 28'(acc_ff - prod_s);
      end
   end

   // Round the average, apply tare, threshold then clamp
   assign rnd_sum     = {1'b0, avg_ff} + 29'h0008000;
   assign filt_raw    = rnd_sum[28:16];
   assign filtered_in = (filt_raw > {1'b0, sew_pkg::LevelMax}) ?
                        sew_pkg::LevelMax : filt_raw[11:0];
   assign tare_eff    = tare_req_ff ? filtered_in : tare_ff;
   assign diff        = $signed({2'b00, filtered_in}) - $signed({2'b00, tare_eff});

   always_comb begin
      level_in = diff[12:0];
      if (diff < $signed({1'b0, threshold_ff})) begin
         level_in = '0;
      end else if (diff > $signed({1'b0, clamp_ff})) begin
         level_in = clamp_ff;
      end
   end

   // Filter state with reset
   always_ff @(posedge clock) begin
      if (reset) begin
         avg_ff  <= '0;
         tare_ff <= '0;
      end else begin
         avg_ff <= avg_in;
         if (cmd.level_en && tare_req_ff) begin
            tare_ff <= filtered_in;
         end
      end
   end

   // Working and output registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         sample_ff   <= req_sample;
         tare_req_ff <= req_tare_pressed;
      end
      if (cmd.mul_en) begin
         prod_ff <= prod_in;
      end
      acc_ff <= acc_in;
      if (cmd.level_en) begin
         filtered_ff <= filtered_in;
         level_ff    <= level_in;
      end
      if (cmd.out_load) begin
         weight_out_ff   <= prod_ff[36:16];
         filtered_out_ff <= filtered_ff;
      end
   end

   assign rsp_weight_centigrams = weight_out_ff;
   assign rsp_filtered_level    = filtered_out_ff;

endmodule

[hw/rtl/scale_ema_tare_weigh.sv]
// ----------------------------------------------------------------------------
// scale_ema_tare_weigh: load-cell moving average, tare and scaling
// Each accepted request yields one result; the seed request gives none.
// Requests are taken only when idle: each runs through seven sequencer steps (four
// passes through one shared multiplier) first; a stalled result holds the sequencer.
// Reset: synchronous; registers take reset values, average and tare clear, unseeded.
// ----------------------------------------------------------------------------
`include "scale_ema_tare_weigh_assert.svh"

module scale_ema_tare_weigh (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_en,
   input  logic [sew_pkg::CsrIdxWidth-1:0]  csr_index,
   input  logic [sew_pkg::CsrDataWidth-1:0] csr_wdata,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [sew_pkg::SampleWidth-1:0]  req_sample,
   input  logic                             req_tare_pressed,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [sew_pkg::WeightWidth-1:0]  rsp_weight_centigrams,
   output logic [sew_pkg::SampleWidth-1:0]  rsp_filtered_level
);

   sew_pkg::dp_cmd_type cmd;

   // Sequencer
   sew_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // Arithmetic and storage
   sew_dp u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .csr_write_en          (csr_write_en),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata),
      .req_sample            (req_sample),
      .req_tare_pressed      (req_tare_pressed),
      .cmd                   (cmd),
      .rsp_weight_centigrams (rsp_weight_centigrams),
      .rsp_filtered_level    (rsp_filtered_level)
   );

   // Never overwrite a waiting result
   `SEW_ASSERT_IMP(a_no_overwrite, cmd.out_load, !rsp_valid || !rsp_stall)
   // A new result appears only after an output load
   `SEW_ASSERT_IMP(a_rsp_from_load, $rose(rsp_valid), $past(cmd.out_load))
   // Loading a request leaves the block busy
   `SEW_ASSERT_NXT(a_busy_after_load, cmd.load, req_stall)
   // Seed, load and output load are exclusive
   `SEW_ASSERT_IMP(a_cmd_exclusive, 1'b1, $onehot0({cmd.load, cmd.seed, cmd.out_load}))

endmodule
